// ----- sv/lz_flagbit_decompressor_top_macros.svh -----
// Assertion macros for the LZ decompressor checker.
`ifndef LZ_FLAGBIT_DECOMPRESSOR_TOP_MACROS_SVH
`define LZ_FLAGBIT_DECOMPRESSOR_TOP_MACROS_SVH
// Implication checked every clock, quiet in reset.
`define LZD_ASSERT(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Implication from an antecedent to a next-cycle consequent.
`define LZD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- sv/lzd_pkg.sv -----
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared types and constants for the flag-bit LZ decompressor.
// ----------------------------------------------------------------------------
package lzd_pkg;
  localparam int WindowDepthDefault = 8192;

  typedef enum logic [3:0] {
    PH_SIZE_LO, PH_SIZE_HI, PH_FIRST, PH_CMD0, PH_CMD1, PH_SBIT1, PH_SBIT2,
    PH_LIT, PH_LONG_HI, PH_LONG_LO, PH_LONG_LEN, PH_SHORT_OFF, PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PARSE, ST_COPY_RD, ST_COPY_WAIT, ST_EMIT
  } fsm_t;

  typedef enum logic [1:0] {
    STAT_DATA = 2'd0, STAT_DONE = 2'd1, STAT_BAD_DIST = 2'd2, STAT_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  data_0;
    logic [7:0]  data_1;
    logic [7:0]  data_2;
    logic [7:0]  data_3;
    logic [2:0]  byte_count;
    logic [1:0]  status;
    logic [15:0] total_out;
    logic        last_of_input;
  } result_t;
endpackage

// ----- sv/lzd_if.sv -----
// ----------------------------------------------------------------------------
// lzd_in_if / lzd_out_if
// Valid/ready channels for compressed bytes and decompressed results.
// ----------------------------------------------------------------------------
interface lzd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_start;
  modport source (output valid, in_byte, stream_start, input ready);
  modport sink (input valid, in_byte, stream_start, output ready);
endinterface

interface lzd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_0;
  logic [7:0]  data_1;
  logic [7:0]  data_2;
  logic [7:0]  data_3;
  logic [2:0]  byte_count;
  logic [1:0]  status;
  logic [15:0] total_out;
  logic        last_of_input;
  modport source (output valid, data_0, data_1, data_2, data_3, byte_count, status,
                  total_out, last_of_input, input ready);
  modport sink (input valid, data_0, data_1, data_2, data_3, byte_count, status,
                total_out, last_of_input, output ready);
endinterface

// ----- sv/lzd_window.sv -----
// ----------------------------------------------------------------------------
// lzd_window
// History window: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lzd_window #(
  parameter int Depth = 8192,
  localparam int Aw = $clog2(Depth)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [Aw-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [Aw-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/lz_flagbit_decompressor_top.sv -----
// ----------------------------------------------------------------------------
// lz_flagbit_decompressor_top
// Flag-bit LZ stream decompressor with a byte-wide history window memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_in takes one compressed byte per transaction; stream_start marks the
//   size low byte of a new stream. m_out gives results of up to four bytes,
//   or a status result (done, bad distance, size overflow); last_of_input
//   marks the final result caused by one input byte.
//   A byte with no output is parsed, then the input is ready again. A literal
//   or a status result passes parse and emit, and emit waits on output stall.
//   A copy spends an address step and a registered read-data step per byte on
//   the window (copy read, copy wait) and one emit step per up to four bytes.
//   The single window read port and the byte-serial copy loop set the rate.
//   Reset clears the parser to wait for the size low byte; the window holds
//   no reset and is only read at written entries, so no clearing pass runs.
//   When the receiver stalls, the result register holds and the block waits;
//   the next byte is taken once the last result of the current byte sits in
//   the result register.
// ----------------------------------------------------------------------------
module lz_flagbit_decompressor_top
  import lzd_pkg::*;
#(
  parameter int WindowDepth = WindowDepthDefault
) (
  input  logic clk,
  input  logic rst,
  lzd_in_if.sink    s_in,
  lzd_out_if.source m_out
);
  localparam int Aw = $clog2(WindowDepth);

  fsm_t    st, st_next;
  phase_t  phase;
  logic [7:0]  flag_bits;
  logic [3:0]  flags_left;
  logic [15:0] declared_size;
  logic [15:0] produced;
  logic [15:0] pending_word;
  logic [2:0]  short_length;
  logic [7:0]  in_b;
  logic        in_ss;

  // copy engine
  logic [15:0] cp_dist;
  logic [8:0]  copy_left;
  logic [31:0] buf_q;
  logic [2:0]  buf_cnt;
  status_t     stat_q;
  result_t     res;
  logic        res_valid;

  // window port
  logic          we;
  logic [Aw-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  lzd_window #(.Depth(WindowDepth)) u_win (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign s_in.ready = (st == ST_IDLE);
  assign m_out.valid = res_valid;
  assign m_out.data_0 = res.data_0;
  assign m_out.data_1 = res.data_1;
  assign m_out.data_2 = res.data_2;
  assign m_out.data_3 = res.data_3;
  assign m_out.byte_count = res.byte_count;
  assign m_out.status = res.status;
  assign m_out.total_out = res.total_out;
  assign m_out.last_of_input = res.last_of_input;

  // Parse combinational: phase after ss, then drain flag bits.
  phase_t     p0, p1;
  logic [7:0] fb0, fb1;
  logic [3:0] fl0, fl1;
  logic [2:0] sl0, sl1;
  logic [15:0] ds0, pc0, pw0;
  logic [15:0] cdist;
  logic [8:0]  clen;
  logic        do_lit, do_cpy, do_done;

  always_comb begin
    p0 = phase; fb0 = flag_bits; fl0 = flags_left; sl0 = short_length;
    ds0 = declared_size; pc0 = produced; pw0 = pending_word;
    if (in_ss) begin
      p0 = PH_SIZE_LO; fb0 = '0; fl0 = '0; sl0 = '0; ds0 = '0; pc0 = '0; pw0 = '0;
    end
    p1 = p0; fb1 = fb0; fl1 = fl0; sl1 = sl0;
    do_lit = 1'b0; do_cpy = 1'b0; do_done = 1'b0;
    cdist = '0; clen = '0;
    unique case (p0)
      PH_SIZE_LO: begin ds0 = {8'd0, in_b}; p1 = PH_SIZE_HI; end
      PH_SIZE_HI: begin ds0 = {in_b, ds0[7:0]}; p1 = PH_FIRST; end
      PH_FIRST, PH_LIT: do_lit = 1'b1;
      PH_LONG_HI: begin pw0 = {in_b, 8'd0}; p1 = PH_LONG_LO; end
      PH_LONG_LO: begin
        pw0 = {pw0[15:8], in_b};
        if (in_b[2:0] != 3'd0) begin
          do_cpy = 1'b1;
          cdist = 16'd8192 - {3'd0, pw0[15:3]};
          clen = {6'd0, in_b[2:0]} + 9'd2;
        end else begin
          p1 = PH_LONG_LEN;
        end
      end
      PH_LONG_LEN: begin
        if (in_b == 8'd0) begin
          do_done = 1'b1;
        end else begin
          do_cpy = 1'b1;
          cdist = 16'd8192 - {3'd0, pw0[15:3]};
          clen = {1'b0, in_b} + 9'd1;
        end
      end
      PH_SHORT_OFF: begin
        do_cpy = 1'b1;
        cdist = 16'd256 - {8'd0, in_b};
        clen = {6'd0, sl0};
      end
      PH_HALT: ;
      PH_CMD0, PH_CMD1, PH_SBIT1, PH_SBIT2: begin fb1 = in_b; fl1 = 4'd8; end
      default: p1 = PH_HALT;
    endcase
  end

  // Flag-bit drain: at most 4 bit phases in a row, from PH_CMD0 after a literal or copy.
  function automatic void drain(input phase_t pi, input logic [7:0] fi,
                                input logic [3:0] li, input logic [2:0] si,
                                output phase_t po, output logic [7:0] fo,
                                output logic [3:0] lo, output logic [2:0] so);
    logic b;
    po = pi; fo = fi; lo = li; so = si;
    for (int k = 0; k < 4; k++) begin
      if ((po == PH_CMD0 || po == PH_CMD1 || po == PH_SBIT1 || po == PH_SBIT2)
          && lo != 4'd0) begin
        b = fo[7];
        fo = {fo[6:0], 1'b0};
        lo = lo - 4'd1;
        unique case (po)
          PH_CMD0: po = b ? PH_LIT : PH_CMD1;
          PH_CMD1: po = b ? PH_LONG_HI : PH_SBIT1;
          PH_SBIT1: begin so = {1'b0, b, 1'b0}; po = PH_SBIT2; end
          default: begin so = (so | {2'd0, b}) + 3'd2; po = PH_SHORT_OFF; end
        endcase
      end
    end
  endfunction

  phase_t     dp;
  logic [7:0] dfb;
  logic [3:0] dfl;
  logic [2:0] dsl;
  always_comb begin
    drain((do_lit || do_cpy) ? PH_CMD0 : p1, fb1, fl1, sl1, dp, dfb, dfl, dsl);
  end

  logic [16:0] need;
  always_comb begin
    need = {1'b0, pc0} + {8'd0, clen};
  end

  logic cpy_ok, lit_ok, halt_now;
  assign cpy_ok = do_cpy && cdist <= pc0 && need <= {1'b0, ds0};
  assign lit_ok = do_lit && pc0 < ds0;
  assign halt_now = do_done || (do_cpy && !cpy_ok) || (do_lit && !lit_ok);

  logic [7:0] cur_byte;
  logic       fwd;
  logic [7:0] last_w;
  assign cur_byte = fwd ? last_w : rdata;

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: if (s_in.valid) st_next = ST_PARSE;
      ST_PARSE: begin
        if (cpy_ok) st_next = ST_COPY_RD;
        else if (do_lit || do_cpy || do_done) st_next = ST_EMIT;
        else st_next = ST_IDLE;
      end
      ST_COPY_RD: st_next = ST_COPY_WAIT;
      ST_COPY_WAIT: begin
        if (buf_cnt == 3'd3 || copy_left == 9'd1) st_next = ST_EMIT;
        else st_next = ST_COPY_RD;
      end
      ST_EMIT: begin
        if (!res_valid || m_out.ready) begin
          if (copy_left != 9'd0) st_next = ST_COPY_RD;
          else st_next = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  assign raddr = produced[Aw-1:0] - cp_dist[Aw-1:0];
  assign we = (st == ST_PARSE && lit_ok) || (st == ST_COPY_WAIT);
  assign waddr = (st == ST_PARSE) ? pc0[Aw-1:0] : produced[Aw-1:0];
  assign wdata = (st == ST_PARSE) ? in_b : cur_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      phase <= PH_SIZE_LO;
      flag_bits <= '0;
      flags_left <= '0;
      declared_size <= '0;
      produced <= '0;
      pending_word <= '0;
      short_length <= '0;
      res_valid <= 1'b0;
      copy_left <= '0;
      buf_cnt <= '0;
      fwd <= 1'b0;
    end else begin
      st <= st_next;
      if (st == ST_EMIT && (!res_valid || m_out.ready)) begin
        res_valid <= 1'b1;
      end else if (res_valid && m_out.ready) begin
        res_valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (s_in.valid) begin
            in_b <= s_in.in_byte;
            in_ss <= s_in.stream_start;
          end
        end
        ST_PARSE: begin
          declared_size <= ds0;
          pending_word <= pw0;
          flag_bits <= dfb;
          flags_left <= dfl;
          short_length <= dsl;
          phase <= halt_now ? PH_HALT : dp;
          produced <= lit_ok ? pc0 + 16'd1 : pc0;
          buf_cnt <= lit_ok ? 3'd1 : 3'd0;
          buf_q <= lit_ok ? {24'd0, in_b} : 32'd0;
          copy_left <= cpy_ok ? clen : 9'd0;
          cp_dist <= cdist;
          fwd <= 1'b0;
          if (do_done) stat_q <= STAT_DONE;
          else if (do_cpy && cdist > pc0) stat_q <= STAT_BAD_DIST;
          else stat_q <= STAT_OVERFLOW;
        end
        ST_COPY_WAIT: begin
          // store one copied byte; forward it if the next read hits it
          buf_q[8*buf_cnt[1:0] +: 8] <= cur_byte;
          buf_cnt <= buf_cnt + 3'd1;
          produced <= produced + 16'd1;
          copy_left <= copy_left - 9'd1;
          last_w <= cur_byte;
          fwd <= (cp_dist == 16'd1);
        end
        ST_EMIT: begin
          if (!res_valid || m_out.ready) begin
            if (buf_cnt != 3'd0) begin
              res <= '{buf_q[7:0], buf_q[15:8], buf_q[23:16], buf_q[31:24], buf_cnt,
                       STAT_DATA, produced, (copy_left == 9'd0)};
            end else begin
              res <= '{8'd0, 8'd0, 8'd0, 8'd0, 3'd0, stat_q, produced, 1'b1};
            end
            buf_cnt <= '0;
            buf_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- sv/lzd_checker.sv -----
// ----------------------------------------------------------------------------
// lzd_checker
// Port-level checks on the decompressor's channels.
// ----------------------------------------------------------------------------
`include "lz_flagbit_decompressor_top_macros.svh"
module lzd_checker
  import lzd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] byte_count,
  input logic [1:0] status,
  input logic       last_of_input
);
  `LZD_ASSERT(a_cnt_range, clk, rst, !out_valid || byte_count <= 3'd4, "byte_count above 4")
  `LZD_ASSERT(a_status_cnt, clk, rst, !out_valid || (status == STAT_DATA) == (byte_count != 3'd0), "status and byte_count disagree")
  `LZD_ASSERT(a_status_last, clk, rst, !out_valid || status == STAT_DATA || last_of_input, "status result not last")
  `LZD_ASSERT_NEXT(a_no_take_busy, clk, rst, in_valid && in_ready, !in_ready, "input taken back to back")
endmodule

bind lz_flagbit_decompressor_top lzd_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(s_in.valid), .in_ready(s_in.ready),
  .out_valid(m_out.valid), .out_ready(m_out.ready),
  .byte_count(m_out.byte_count), .status(m_out.status),
  .last_of_input(m_out.last_of_input)
);
